// File: rtl/egl_pkg.sv
// egl_pkg: shared types and constants for the edge gap line check block
// no dependencies; imported by every module of the block
package egl_pkg;

    // field widths
    localparam int COORD_W = 9;
    localparam int SCOORD_W = 11;
    localparam int CFG_W = 10;
    localparam int BAND_W = 4;
    localparam int GAP_W = 10;
    localparam int IDX_W = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // reset values of the registers
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH = 10'd512;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 10'd512;
    localparam logic [BAND_W-1:0] EDGE_WIDTH = 4'd3;
    localparam logic [GAP_W-1:0] GAP_SIZE = 10'd15;

    // largest gap count a walk can give
    localparam logic [GAP_W-1:0] GAP_MAX = 10'd512;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_EDGE_BAND    = 2'd2,
        REG_GAP_LIMIT    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TEST  = 1'b1
    } op_t;

    // pixel read request, coordinates may be negative or past the image
    typedef struct packed {
        logic                       rd_en;
        logic signed [SCOORD_W-1:0] x;
        logic signed [SCOORD_W-1:0] y;
    } pix_rd_t;

    // pixel write request
    typedef struct packed {
        logic               wr_en;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               value;
    } pix_wr_t;

endpackage

// File: rtl/egl_bitmap.sv
// egl_bitmap: one-bit edge map store with image bounds check and registered read
// depends on egl_pkg
module egl_bitmap #(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [egl_pkg::CFG_W-1:0]   image_width,
    input  logic [egl_pkg::CFG_W-1:0]   image_height,
    input  egl_pkg::pix_rd_t            rd,
    input  egl_pkg::pix_wr_t            wr,
    output logic                        hit
);
    import egl_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 1 << (XW + YW);

    logic                 mem [DEPTH];
    logic                 mem_q_reg;
    logic                 ok_reg;
    logic                 rd_in;
    logic                 wr_in;
    logic [CFG_W-1:0]     rx;
    logic [CFG_W-1:0]     ry;
    logic [XW+YW-1:0]     rd_addr;
    logic [XW+YW-1:0]     wr_addr;

    // read bounds: non-negative, inside the image and inside the store
    assign rx = rd.x[CFG_W-1:0];
    assign ry = rd.y[CFG_W-1:0];
    assign rd_in = rd.rd_en && !rd.x[SCOORD_W-1] && !rd.y[SCOORD_W-1]
                   && (rx < image_width) && (ry < image_height)
                   && ({22'd0, rx} < 32'(MAX_WIDTH))
                   && ({22'd0, ry} < 32'(MAX_HEIGHT));
    assign rd_addr = {YW'(ry), XW'(rx)};

    // writes outside the store are dropped
    assign wr_in = wr.wr_en && ({23'd0, wr.x} < 32'(MAX_WIDTH))
                   && ({23'd0, wr.y} < 32'(MAX_HEIGHT));
    assign wr_addr = {YW'(wr.y), XW'(wr.x)};

    // edge map write port
    always_ff @(posedge clk)
    begin
        if (wr_in)
        begin
            mem[wr_addr] <= wr.value;
        end
    end

    // edge map read port
    always_ff @(posedge clk)
    begin
        if (rd_in)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // marks a read that landed inside the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= rd_in;
        end
    end

    assign hit = ok_reg & mem_q_reg;

endmodule

// File: rtl/edge_gap_line_check_core.sv
// edge_gap_line_check_core: top level, gap test of a line between two points
// depends on egl_pkg and egl_bitmap
//
//  channel   dir  signals                          moves
//  s_*       in   s_tvalid s_tready s_tdata[39:0]  pixel write or point pair test
//  m_*       out  m_tvalid m_tready m_tdata[15:0]  connected flag and gap count
//  cfg_*     in   cfg_we cfg_index cfg_data        register writes, no read-back
//
// a pixel write goes to the map on acceptance; a test walks the major-axis span,
// reading each step's band pixels from the map, one band pixel read per cycle within a step.
// the result sits in an output register; the next item is taken while it waits,
// and a later test holds in its last state until the register is free.
// the edge map gets no clearing after reset; registers reset to their defaults.
module edge_gap_line_check_core #(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation, first_x, first_y, second_x, second_y, edge_bit, zero fill
    input  logic [egl_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // connected, gap_count, zero fill
    output logic [egl_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [egl_pkg::IDX_W-1:0]     cfg_index,
    input  logic [egl_pkg::CFG_W-1:0]     cfg_data
);
    import egl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SPAN   = 6'b000010,
        S_ORIENT = 6'b000100,
        S_READ   = 6'b001000,
        S_STEP   = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic               operation;
    logic [COORD_W-1:0] first_x, first_y, second_x, second_y;
    logic               edge_bit;

    assign operation = s_tdata[0];
    assign first_x   = s_tdata[9:1];
    assign first_y   = s_tdata[18:10];
    assign second_x  = s_tdata[27:19];
    assign second_y  = s_tdata[36:28];
    assign edge_bit  = s_tdata[37];

    // configuration
    logic [CFG_W-1:0]  image_width_reg, image_height_reg;
    logic [BAND_W-1:0] edge_band_reg;
    logic [GAP_W-1:0]  gap_limit_reg;

    // walk state
    logic [COORD_W-1:0]        x1_reg, y1_reg, x2_reg, y2_reg;
    logic                      x_major_reg;
    logic [COORD_W-1:0]        lo_major_reg;
    logic [COORD_W-1:0]        d_reg;
    logic signed [COORD_W:0]   dm_reg;
    logic [COORD_W-1:0]        line_reg, line_next;
    logic [COORD_W-1:0]        rem_reg, rem_next;
    logic [COORD_W-1:0]        k_reg;
    logic signed [BAND_W:0]    off_reg;
    logic                      found_reg;
    logic [GAP_W-1:0]          gaps_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_conn_reg;
    logic [GAP_W-1:0]          out_gaps_reg;

    logic     s_acc;
    logic     out_free;
    logic     hit;
    logic     step_found;
    pix_rd_t  rd_req;
    pix_wr_t  wr_req;

    // span and orientation helpers
    logic signed [COORD_W:0]   dx, dy;
    logic [COORD_W:0]          adx, ady;
    logic [COORD_W-1:0]        p1_maj, p1_min, p2_maj, p2_min;
    logic [COORD_W-1:0]        lo_min, hi_maj, hi_min, lo_maj;
    logic signed [BAND_W:0]    band_s;
    logic signed [SCOORD_W-1:0] minor_c, major_c;
    logic signed [COORD_W+1:0] rem_sum;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign band_s   = $signed({1'b0, edge_band_reg});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            edge_band_reg    <= EDGE_WIDTH;
            gap_limit_reg    <= GAP_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_EDGE_BAND:    edge_band_reg    <= cfg_data[BAND_W-1:0];
                REG_GAP_LIMIT:    gap_limit_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // spans and major axis choice; equal spans walk along y
    always_comb
    begin
        dx  = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
        dy  = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
        adx = dx[COORD_W] ? 10'(-dx) : 10'(dx);
        ady = dy[COORD_W] ? 10'(-dy) : 10'(dy);
    end

    // endpoints by axis, low end first
    always_comb
    begin
        p1_maj = x_major_reg ? x1_reg : y1_reg;
        p1_min = x_major_reg ? y1_reg : x1_reg;
        p2_maj = x_major_reg ? x2_reg : y2_reg;
        p2_min = x_major_reg ? y2_reg : x2_reg;
        if (p1_maj < p2_maj)
        begin
            lo_maj = p1_maj;
            lo_min = p1_min;
            hi_maj = p2_maj;
            hi_min = p2_min;
        end
        else
        begin
            lo_maj = p2_maj;
            lo_min = p2_min;
            hi_maj = p1_maj;
            hi_min = p1_min;
        end
    end

    // band pixel coordinates for the current offset
    always_comb
    begin
        minor_c = $signed({2'b00, line_reg}) + SCOORD_W'(off_reg);
        major_c = $signed({2'b00, 9'(lo_major_reg + k_reg)});
        rd_req.rd_en = (state_reg == S_READ);
        rd_req.x = x_major_reg ? major_c : minor_c;
        rd_req.y = x_major_reg ? minor_c : major_c;
    end

    // pixel writes go straight to the map on acceptance
    always_comb
    begin
        wr_req.wr_en = s_acc && (op_t'(operation) == OP_WRITE);
        wr_req.x     = first_x;
        wr_req.y     = first_y;
        wr_req.value = edge_bit;
    end

    // line point update: remainder stays in [0, d), one correction per step
    always_comb
    begin
        rem_sum   = $signed({2'b00, rem_reg}) + SCOORD_W'(dm_reg);
        line_next = line_reg;
        rem_next  = rem_sum[COORD_W-1:0];
        if (!dm_reg[COORD_W])
        begin
            if (rem_sum >= $signed({2'b00, d_reg}))
            begin
                rem_next  = 9'(rem_sum - $signed({2'b00, d_reg}));
                line_next = line_reg + 9'd1;
            end
        end
        else if (rem_sum[SCOORD_W-1])
        begin
            rem_next  = 9'(rem_sum + $signed({2'b00, d_reg}));
            line_next = line_reg - 9'd1;
        end
    end

    assign step_found = found_reg | hit;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (op_t'(operation) == OP_TEST))
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:   state_next = S_ORIENT;
            S_ORIENT: state_next = S_READ;
            S_READ:
            begin
                if (off_reg == band_s)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:   state_next = (k_reg == d_reg) ? S_EMIT : S_READ;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x1_reg <= first_x;
                y1_reg <= first_y;
                x2_reg <= second_x;
                y2_reg <= second_y;
            end
            S_SPAN:
            begin
                x_major_reg <= (adx > ady);
            end
            S_ORIENT:
            begin
                lo_major_reg <= lo_maj;
                d_reg        <= hi_maj - lo_maj;
                dm_reg       <= $signed({1'b0, hi_min}) - $signed({1'b0, lo_min});
                line_reg     <= lo_min;
                rem_reg      <= '0;
                k_reg        <= '0;
                off_reg      <= -band_s;
                found_reg    <= 1'b0;
                gaps_reg     <= '0;
            end
            S_READ:
            begin
                found_reg <= step_found;
                off_reg   <= off_reg + 5'sd1;
            end
            S_STEP:
            begin
                found_reg <= 1'b0;
                off_reg   <= -band_s;
                if (!step_found)
                begin
                    gaps_reg <= gaps_reg + 10'd1;
                end
                if (k_reg != d_reg)
                begin
                    k_reg    <= k_reg + 9'd1;
                    line_reg <= line_next;
                    rem_reg  <= rem_next;
                end
            end
            S_EMIT:   ;
            default:  ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_gaps_reg <= gaps_reg;
            out_conn_reg <= (gaps_reg < gap_limit_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_gaps_reg, out_conn_reg};

    egl_bitmap #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_bitmap (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .rd           (rd_req),
        .wr           (wr_req),
        .hit          (hit)
    );

endmodule

// File: rtl/egl_checker.sv
// egl_checker: port-level checks for edge_gap_line_check_core, bound to the top
// depends on egl_pkg and edge_gap_line_check_core
module egl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [egl_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [egl_pkg::M_DATA_W-1:0]  m_tdata
);
    import egl_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a test item occupies the block for the next cycle
    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (op_t'(s_tdata[0]) == OP_TEST) |=> !s_tready)
        else $error("input taken during a test");

    // a pixel write leaves the input ready in the next cycle
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (op_t'(s_tdata[0]) == OP_WRITE) |=> s_tready)
        else $error("pixel write held the input");

    // gap count never exceeds GAP_MAX, the largest a walk can give
    a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:1] <= GAP_MAX))
        else $error("gap count out of range");

endmodule

bind edge_gap_line_check_core egl_checker u_egl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/edge_gap_line_check_monitor.sv
// edge_gap_line_check_monitor: watches the item, result and register ports of the
// line gap block, predicts every test verdict and compares it; depends on egl_pkg
module edge_gap_line_check_monitor
    import egl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // operation, first_x, first_y, second_x, second_y, edge_bit, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // connected, gap_count, zero fill
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_W = 512;
    localparam int MAP_H = 512;

    typedef struct {
        logic               connected;
        logic [GAP_W-1:0]   gap_count;
    } line_verdict_t;

    // own copy of the map and the registers
    bit                edge_map [0:MAP_W*MAP_H-1];
    logic [CFG_W-1:0]  img_w;
    logic [CFG_W-1:0]  img_h;
    logic [BAND_W-1:0] band;
    logic [GAP_W-1:0]  gap_limit;

    line_verdict_t verdict_q [$];
    int            mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // walk the major axis and count steps with no edge in the band
    function automatic int unsigned count_line_gaps(int ax, int ay, int bx, int by);
        int          w, h, b, adx, ady, k, off;
        int          lo_maj, lo_min, hi_maj, hi_min, span, rise, mid, px, py;
        bit          x_major, hit;
        int unsigned gaps;
        w = (img_w > MAP_W) ? MAP_W : int'(img_w);
        h = (img_h > MAP_H) ? MAP_H : int'(img_h);
        b = int'(band);
        adx = (bx > ax) ? bx - ax : ax - bx;
        ady = (by > ay) ? by - ay : ay - by;
        x_major = adx > ady;
        // lower major coordinate is the start, ties go to the second point
        if ((x_major ? ax : ay) < (x_major ? bx : by))
        begin
            lo_maj = x_major ? ax : ay;
            lo_min = x_major ? ay : ax;
            hi_maj = x_major ? bx : by;
            hi_min = x_major ? by : bx;
        end
        else
        begin
            lo_maj = x_major ? bx : by;
            lo_min = x_major ? by : bx;
            hi_maj = x_major ? ax : ay;
            hi_min = x_major ? ax : ay;
            hi_min = x_major ? ay : ax;
        end
        span = hi_maj - lo_maj;
        rise = hi_min - lo_min;
        gaps = 0;
        for (k = 0; k <= span; k++)
        begin
            // numerator never negative, so division is a plain floor
            mid = (span > 0) ? (lo_min * span + k * rise) / span : lo_min;
            hit = 1'b0;
            for (off = -b; off <= b; off++)
            begin
                px = x_major ? lo_maj + k : mid + off;
                py = x_major ? mid + off : lo_maj + k;
                if (px >= 0 && py >= 0 && px < w && py < h && edge_map[py * MAP_W + px])
                    hit = 1'b1;
            end
            if (!hit)
                gaps++;
        end
        return gaps;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        line_verdict_t want;
        logic [8:0]    fx, fy, sx, sy;
        int unsigned   gaps;
        if (!rst_n)
        begin
            img_w     <= RST_IMAGE_WIDTH;
            img_h     <= RST_IMAGE_HEIGHT;
            band      <= EDGE_WIDTH;
            gap_limit <= GAP_SIZE;
            pending   <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_IMAGE_WIDTH:  img_w     <= cfg_data;
                    REG_IMAGE_HEIGHT: img_h     <= cfg_data;
                    REG_EDGE_BAND:    band      <= cfg_data[BAND_W-1:0];
                    REG_GAP_LIMIT:    gap_limit <= cfg_data;
                    default: ;
                endcase
            end

            // result items against the oldest verdict
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("result %h with no test waiting", m_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.connected)
                        report_mismatch($sformatf("connected %b, predicted %b",
                                                  m_tdata[0], want.connected));
                    if (m_tdata[GAP_W:1] !== want.gap_count)
                        report_mismatch($sformatf("gap_count %0d, predicted %0d",
                                                  m_tdata[GAP_W:1], want.gap_count));
                end
            end

            // input items: writes update the map, tests get a verdict
            if (s_tvalid && s_tready)
            begin
                fx = s_tdata[9:1];
                fy = s_tdata[18:10];
                sx = s_tdata[27:19];
                sy = s_tdata[36:28];
                if (op_t'(s_tdata[0]) == OP_WRITE)
                    edge_map[{fy, fx}] = s_tdata[37];
                else
                begin
                    gaps = count_line_gaps(fx, fy, sx, sy);
                    want.connected = gaps < gap_limit;
                    want.gap_count = gaps[GAP_W-1:0];
                    verdict_q.push_back(want);
                end
            end

            pending <= verdict_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
// testbench: stimulus and verdict for edge_gap_line_check_core
// depends on egl_pkg, the block rtl and edge_gap_line_check_monitor
module testbench;
    import egl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_W         = 512;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    int                  fail_count;
    int                  pending;

    // pixels already written, so no test reads an unwritten one
    bit written [0:MAP_W*MAP_W-1];
    int img_w;
    int img_h;
    int band;
    bit calm;
    int hold_requests;
    int hold_served;

    edge_gap_line_check_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    edge_gap_line_check_monitor line_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #48_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, quiet when calm, long hold on request
    initial
    begin
        hold_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > MAP_W - 1) ? MAP_W - 1 : v);
    endfunction

    // offer one item, with random idle cycles first
    task automatic send_item(op_t op, logic [8:0] fx, logic [8:0] fy,
                             logic [8:0] sx, logic [8:0] sy, logic eb);
        while (!calm && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, eb, sy, sx, fy, fx, op};
        do @(posedge clk); while (!s_tready);
        if (op == OP_WRITE)
            written[{fy, fx}] = 1'b1;
    endtask

    task automatic write_pixel(int x, int y, bit v);
        send_item(OP_WRITE, x, y, $urandom, $urandom, v);
    endtask

    // sender stops until every result has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_config(int w, int h, int b, int lim);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= REG_EDGE_BAND;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= REG_GAP_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        img_w = w;
        img_h = h;
        band  = b;
    endtask

    // fill every unwritten in-image pixel the test could read, then test
    task automatic run_test(int ax, int ay, int bx, int by, int pct);
        int w, h, x, y, x0, x1, y0, y1;
        w  = (img_w > MAP_W) ? MAP_W : img_w;
        h  = (img_h > MAP_W) ? MAP_W : img_h;
        x0 = ((ax < bx) ? ax : bx) - band;
        x1 = ((ax > bx) ? ax : bx) + band;
        y0 = ((ay < by) ? ay : by) - band;
        y1 = ((ay > by) ? ay : by) + band;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > w - 1) x1 = w - 1;
        if (y1 > h - 1) y1 = h - 1;
        for (y = y0; y <= y1; y++)
            for (x = x0; x <= x1; x++)
                if (!written[y * MAP_W + x])
                    write_pixel(x, y, $urandom_range(99) < pct);
        send_item(OP_TEST, ax, ay, bx, by, $urandom_range(1));
    endtask

    // mostly short tests near a base point, some stray writes and long lines
    task automatic random_items(int count, int bx, int by, bit full_ok);
        int i, kind, ax, ay, cx, cy;
        int density [5] = '{0, 20, 50, 85, 100};
        for (i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            ax = clamp_coord(bx + int'($urandom_range(23)));
            ay = clamp_coord(by + int'($urandom_range(23)));
            cx = clamp_coord(ax + int'($urandom_range(32)) - 16);
            cy = clamp_coord(ay + int'($urandom_range(32)) - 16);
            if (kind < 25)
            begin
                if ($urandom_range(1))
                    write_pixel(ax, ay, $urandom_range(1));
                else
                    write_pixel($urandom_range(511), $urandom_range(511), $urandom_range(1));
            end
            else
            begin
                if (kind < 35)
                begin
                    cx = ax;
                    cy = ay;
                end
                else if (kind < 45 && full_ok)
                begin
                    ax = $urandom_range(511);
                    ay = $urandom_range(511);
                    cx = $urandom_range(511);
                    cy = $urandom_range(511);
                end
                run_test(ax, ay, cx, cy, density[$urandom_range(4)]);
            end
        end
    endtask

    initial
    begin : stimulus
        int x, y;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        calm = 1'b0;
        hold_requests = 0;
        img_w = RST_IMAGE_WIDTH;
        img_h = RST_IMAGE_HEIGHT;
        band  = EDGE_WIDTH;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: corners of the full map
        run_test(0, 0, 0, 0, 100);
        run_test(511, 511, 511, 511, 0);
        run_test(505, 509, 511, 511, 50);

        // tiny map with an edge along row one
        set_config(4, 4, 1, 2);
        for (y = 0; y < 4; y++)
            for (x = 0; x < 4; x++)
                write_pixel(x, y, y == 1);
        run_test(0, 1, 3, 1, 0);
        // endpoints given high end first
        run_test(3, 2, 0, 1, 0);
        // vertical line crossing the edge once
        run_test(2, 0, 2, 3, 0);
        // equal spans walk along y
        run_test(0, 0, 3, 3, 0);
        // identical points
        run_test(3, 3, 3, 3, 0);
        // cleared pixel opens one gap
        write_pixel(1, 1, 0);
        run_test(0, 1, 3, 1, 0);
        // steps past the image edge count as gaps
        run_test(2, 1, 511, 1, 0);
        run_test(0, 0, 511, 511, 0);
        run_test(511, 0, 0, 511, 0);

        // no band, nothing can connect
        set_config(24, 20, 0, 0);
        random_items(25, 0, 0, 1'b1);

        // oversized dimensions saturate, widest band, top limit
        set_config(1023, 600, 15, 1023);
        random_items(20, 488, 488, 1'b0);

        // zero width and zero height: every step a gap
        set_config(0, 5, 7, 1);
        run_test(0, 0, 511, 511, 0);
        random_items(12, 0, 0, 1'b1);
        set_config(512, 0, 2, 512);
        run_test(0, 0, 511, 0, 0);
        run_test(0, 0, 511, 511, 0);
        random_items(8, 0, 0, 1'b1);

        // long hold on the result side, then a pause for all results
        set_config(40, 40, $urandom_range(1, 4), $urandom_range(1, 10));
        hold_requests++;
        random_items(22, 8, 8, 1'b1);
        wait_results();
        random_items(23, 8, 8, 1'b1);

        // full map, no idling on either side
        set_config(512, 512, 2, 2);
        calm = 1'b1;
        random_items(30, $urandom_range(488), $urandom_range(488), 1'b0);
        calm = 1'b0;

        wait_results();
        repeat (32) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
